@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/i2cmbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2cmbe_pkg;

  localparam int PHASE_W = 5;
  localparam int MODE_W  = 3;
  localparam int TICK_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int BIT_W   = 4;

  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [MODE_W-1:0]  mode_t;

  localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd4;

  // Command codes.
  localparam mode_t MODE_START    = 3'd0;
  localparam mode_t MODE_STOP     = 3'd1;
  localparam mode_t MODE_WRITE    = 3'd2;
  localparam mode_t MODE_READ_ACK = 3'd3;
  localparam mode_t MODE_READ_NAK = 3'd4;

  // Bus sequencer phases.
  localparam phase_t PH_IDLE        = 5'd0;
  localparam phase_t PH_START_A     = 5'd1;
  localparam phase_t PH_START_B     = 5'd2;
  localparam phase_t PH_STOP_A      = 5'd3;
  localparam phase_t PH_STOP_B      = 5'd4;
  localparam phase_t PH_STOP_C      = 5'd5;
  localparam phase_t PH_WR_LOW      = 5'd6;
  localparam phase_t PH_WR_HIGH     = 5'd7;
  localparam phase_t PH_WR_ACK_LOW  = 5'd8;
  localparam phase_t PH_WR_ACK_HIGH = 5'd9;
  localparam phase_t PH_RD_LOW      = 5'd10;
  localparam phase_t PH_RD_HIGH     = 5'd11;
  localparam phase_t PH_RD_ACK_LOW  = 5'd12;
  localparam phase_t PH_RD_ACK_HIGH = 5'd13;

  localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

endpackage

`default_nettype wire

@@ design/i2c_master_byte_engine.sv @@
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------------
// in       | in_valid/in_ready  | cmd_valid, mode, write_byte, sda_in (one bus tick)
// out      | out_valid/out_ready| scl_level, sda_level, busy_res, done_res,
//          |                    | read_byte, ack_ok (state after that tick)
// cfg      | cfg_write_en       | cfg_write_data (phase_ticks)
//
// Every input transaction is one bus tick and yields exactly one output transaction.
// One tick is taken per cycle while in_ready is high; the sequencer state and the
// result register update together on acceptance, so the result appears in the next cycle.
// in_ready is low only while the result register holds a transaction not yet taken.
// Synchronous active-high reset idles the sequencer with both lines released.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine
  import i2cmbe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write_en,
  input  wire logic [TICK_W-1:0] cfg_write_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              cmd_valid,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [BYTE_W-1:0] write_byte,
  input  wire logic              sda_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   scl_level,
  output logic                   sda_level,
  output logic                   busy_res,
  output logic                   done_res,
  output logic [BYTE_W-1:0]      read_byte,
  output logic                   ack_ok
);

  logic [TICK_W-1:0] phase_ticks;
  phase_t            phase, phase_next;
  logic [BIT_W-1:0]  bit_count, bit_count_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [BYTE_W-1:0] shift_byte, shift_byte_next;
  mode_t             current_cmd, current_cmd_next;
  logic              scl, scl_next;
  logic              sda, sda_next;
  logic              ack_flag, ack_flag_next;
  logic [BYTE_W-1:0] read_hold, read_hold_next;
  logic              done_next;

  logic              in_accept;
  logic [TICK_W-1:0] limit;
  logic [TICK_W:0]   tick_inc;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // A phase length of zero behaves as one tick.
  assign limit    = (phase_ticks == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : phase_ticks;
  assign tick_inc = {1'b0, tick_count} + {{TICK_W{1'b0}}, 1'b1};

  always_comb begin
    logic [BIT_W-1:0] bits_done;
    phase_next       = phase;
    bit_count_next   = bit_count;
    tick_count_next  = tick_count;
    shift_byte_next  = shift_byte;
    current_cmd_next = current_cmd;
    scl_next         = scl;
    sda_next         = sda;
    ack_flag_next    = ack_flag;
    read_hold_next   = read_hold;
    done_next        = 1'b0;
    bits_done        = bit_count + {{(BIT_W-1){1'b0}}, 1'b1};

    if (phase == PH_IDLE) begin
      if (cmd_valid && mode <= MODE_READ_NAK) begin
        current_cmd_next = mode;
        bit_count_next   = '0;
        tick_count_next  = '0;
        unique case (mode)
          MODE_START: begin
            sda_next   = 1'b1;
            scl_next   = 1'b1;
            phase_next = PH_START_A;
          end
          MODE_STOP: begin
            scl_next   = 1'b0;
            sda_next   = 1'b0;
            phase_next = PH_STOP_A;
          end
          MODE_WRITE: begin
            shift_byte_next = write_byte;
            sda_next        = write_byte[BYTE_W-1];
            phase_next      = PH_WR_LOW;
          end
          default: begin
            sda_next   = 1'b1;
            phase_next = PH_RD_LOW;
          end
        endcase
      end
    end else if (tick_inc < {1'b0, limit}) begin
      tick_count_next = tick_inc[TICK_W-1:0];
    end else begin
      tick_count_next = '0;
      unique case (phase)
        PH_START_A: begin
          sda_next   = 1'b0;
          phase_next = PH_START_B;
        end
        PH_START_B: begin
          scl_next   = 1'b0;
          phase_next = PH_IDLE;
          done_next  = 1'b1;
        end
        PH_STOP_A: begin
          scl_next   = 1'b1;
          phase_next = PH_STOP_B;
        end
        PH_STOP_B: begin
          sda_next   = 1'b1;
          phase_next = PH_STOP_C;
        end
        PH_STOP_C: begin
          phase_next = PH_IDLE;
          done_next  = 1'b1;
        end
        PH_WR_LOW: begin
          scl_next   = 1'b1;
          phase_next = PH_WR_HIGH;
        end
        PH_WR_HIGH: begin
          scl_next       = 1'b0;
          bit_count_next = bits_done;
          if (bits_done < BITS_PER_BYTE) begin
            shift_byte_next = {shift_byte[BYTE_W-2:0], 1'b0};
            sda_next        = shift_byte[BYTE_W-2];
            phase_next      = PH_WR_LOW;
          end else begin
            // Release SDA so the slave can drive its acknowledge.
            sda_next   = 1'b1;
            phase_next = PH_WR_ACK_LOW;
          end
        end
        PH_WR_ACK_LOW: begin
          scl_next      = 1'b1;
          ack_flag_next = !sda_in;
          phase_next    = PH_WR_ACK_HIGH;
        end
        PH_WR_ACK_HIGH: begin
          scl_next   = 1'b0;
          phase_next = PH_IDLE;
          done_next  = 1'b1;
        end
        PH_RD_LOW: begin
          scl_next        = 1'b1;
          shift_byte_next = {shift_byte[BYTE_W-2:0], sda_in};
          phase_next      = PH_RD_HIGH;
        end
        PH_RD_HIGH: begin
          scl_next       = 1'b0;
          bit_count_next = bits_done;
          if (bits_done < BITS_PER_BYTE) begin
            phase_next = PH_RD_LOW;
          end else begin
            sda_next   = (current_cmd != MODE_READ_ACK);
            phase_next = PH_RD_ACK_LOW;
          end
        end
        PH_RD_ACK_LOW: begin
          scl_next   = 1'b1;
          phase_next = PH_RD_ACK_HIGH;
        end
        PH_RD_ACK_HIGH: begin
          scl_next       = 1'b0;
          read_hold_next = shift_byte;
          phase_next     = PH_IDLE;
          done_next      = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_write_en) begin
      phase_ticks <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      tick_count  <= '0;
      shift_byte  <= '0;
      current_cmd <= MODE_START;
      scl         <= 1'b1;
      sda         <= 1'b1;
      ack_flag    <= 1'b0;
      read_hold   <= '0;
    end else if (in_accept) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      tick_count  <= tick_count_next;
      shift_byte  <= shift_byte_next;
      current_cmd <= current_cmd_next;
      scl         <= scl_next;
      sda         <= sda_next;
      ack_flag    <= ack_flag_next;
      read_hold   <= read_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      scl_level <= scl_next;
      sda_level <= sda_next;
      busy_res  <= (phase_next != PH_IDLE);
      done_res  <= done_next;
      read_byte <= read_hold_next;
      ack_ok    <= ack_flag_next;
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_bit_count_range, bit_count <= BITS_PER_BYTE)
  `ASSERT_IMPLIES(a_idle_tick_clear, phase == PH_IDLE, tick_count == '0)
  `ASSERT_IMPLIES(a_done_not_busy, out_valid && done_res, !busy_res)
  `ASSERT_NEXT(a_start_leaves_idle,
    in_accept && phase == PH_IDLE && cmd_valid && mode == MODE_START,
    phase == PH_START_A && scl && sda)

endmodule

`default_nettype wire
